>>> design/lc3ex_pkg.sv
// ----------------------------------------------------------------------------
// lc3ex_pkg
// Shared types, constants and opcode codes of the LC-3 style executor.
// ----------------------------------------------------------------------------
package lc3ex_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int RF_DEPTH  = 8;
    localparam int RF_BITS   = $clog2(RF_DEPTH);

    typedef logic [15:0]          t_word;
    typedef logic [ADDR_BITS-1:0] t_maddr;
    typedef logic [RF_BITS-1:0]   t_raddr;
    typedef logic [2:0]           t_flags;

    localparam t_word  MCR_ADDR  = 16'hFFFE;
    localparam t_word  DSR_ADDR  = 16'hFE04;
    localparam t_word  DDR_ADDR  = 16'hFE06;
    localparam t_word  CTRL_INIT = 16'h8000;
    localparam t_raddr LINK_REG  = t_raddr'(7);

    localparam t_flags FLAG_N = 3'b100;
    localparam t_flags FLAG_Z = 3'b010;
    localparam t_flags FLAG_P = 3'b001;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_RET  = 4'd12,
        OP_RES  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } t_op;

    typedef struct packed {
        t_word  ir;
        t_word  pc1;
        t_word  ra;
        t_word  rb;
        t_word  ma;
        t_word  mq;
        t_flags flags;
    } t_exec_in;

    typedef struct packed {
        t_word  pc;
        t_flags flags;
        logic   rf_we;
        t_raddr rf_waddr;
        t_word  rf_wdata;
        logic   mem_we;
        t_word  mem_waddr;
        t_word  mem_wdata;
    } t_exec_out;

    typedef struct packed {
        t_word      pc;
        t_flags     cc;
        logic       halted;
        logic       char_valid;
        logic [7:0] char_code;
    } t_result;

endpackage

>>> design/lc3ex_in_if.sv
// ----------------------------------------------------------------------------
// lc3ex_in_if
// Input channel: load, start and step words.
// ----------------------------------------------------------------------------
interface lc3ex_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [15:0] data;

    modport source (output valid, output opcode, output address, output data, input ready);
    modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

>>> design/lc3ex_out_if.sv
// ----------------------------------------------------------------------------
// lc3ex_out_if
// Output channel: one status word per input word.
// ----------------------------------------------------------------------------
interface lc3ex_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] program_counter;
    logic [2:0]  cond_codes;
    logic        halted;
    logic        char_valid;
    logic [7:0]  char_code;

    modport source (output valid, output program_counter, output cond_codes,
                    output halted, output char_valid, output char_code, input ready);
    modport sink   (input valid, input program_counter, input cond_codes,
                    input halted, input char_valid, input char_code, output ready);
endinterface

>>> design/lc3ex_ram.sv
// ----------------------------------------------------------------------------
// lc3ex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lc3ex_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

>>> design/lc3ex_exec.sv
// ----------------------------------------------------------------------------
// lc3ex_exec
// Execute stage: next PC, register and memory writes, condition codes.
// ----------------------------------------------------------------------------
module lc3ex_exec (
    input  lc3ex_pkg::t_exec_in  i_x,
    output lc3ex_pkg::t_exec_out o_y
);
    import lc3ex_pkg::*;

    t_word off9, off6, off11, imm5, opnd;
    t_op   op;

    assign op    = t_op'(i_x.ir[15:12]);
    assign off9  = {{7{i_x.ir[8]}}, i_x.ir[8:0]};
    assign off6  = {{10{i_x.ir[5]}}, i_x.ir[5:0]};
    assign off11 = {{5{i_x.ir[10]}}, i_x.ir[10:0]};
    assign imm5  = {{11{i_x.ir[4]}}, i_x.ir[4:0]};
    assign opnd  = i_x.ir[5] ? imm5 : i_x.rb;

    always_comb begin
        logic set_cc;
        set_cc        = 1'b0;
        o_y.pc        = i_x.pc1;
        o_y.flags     = i_x.flags;
        o_y.rf_we     = 1'b0;
        o_y.rf_waddr  = i_x.ir[11:9];
        o_y.rf_wdata  = i_x.ra;
        o_y.mem_we    = 1'b0;
        o_y.mem_waddr = i_x.pc1 + off9;
        o_y.mem_wdata = i_x.ra;
        case (op)
            OP_BR: begin
                if ((i_x.ir[11:9] & i_x.flags) != 3'b000) begin
                    o_y.pc = i_x.pc1 + off9;
                end
            end
            OP_ADD: begin
                o_y.rf_we = 1'b1; set_cc = 1'b1;
                o_y.rf_wdata = i_x.ra + opnd;
            end
            OP_AND: begin
                o_y.rf_we = 1'b1; set_cc = 1'b1;
                o_y.rf_wdata = i_x.ra & opnd;
            end
            OP_NOT: begin
                o_y.rf_we = 1'b1; set_cc = 1'b1;
                o_y.rf_wdata = ~i_x.ra;
            end
            OP_LD: begin
                o_y.rf_we = 1'b1; set_cc = 1'b1;
                o_y.rf_wdata = i_x.ma;
            end
            OP_LDI, OP_LDR: begin
                o_y.rf_we = 1'b1; set_cc = 1'b1;
                o_y.rf_wdata = i_x.mq;
            end
            OP_LEA: begin
                o_y.rf_we = 1'b1; set_cc = 1'b1;
                o_y.rf_wdata = i_x.pc1 + off9;
            end
            OP_ST: begin
                o_y.mem_we = 1'b1;
            end
            OP_STI: begin
                o_y.mem_we = 1'b1;
                o_y.mem_waddr = i_x.ma;
            end
            OP_STR: begin
                o_y.mem_we = 1'b1;
                o_y.mem_waddr = i_x.ra + off6;
                o_y.mem_wdata = i_x.rb;
            end
            OP_JSR: begin
                o_y.rf_we = 1'b1;
                o_y.rf_waddr = LINK_REG;
                o_y.rf_wdata = i_x.pc1;
                o_y.pc = i_x.pc1 + off11;
            end
            OP_RET: begin
                o_y.pc = i_x.ra;
            end
            OP_TRAP: begin
                o_y.rf_we = 1'b1;
                o_y.rf_waddr = LINK_REG;
                o_y.rf_wdata = i_x.pc1;
                o_y.pc = i_x.ma;
            end
            default: begin
            end
        endcase
        if (set_cc) begin
            if (o_y.rf_wdata == 16'h0000) begin
                o_y.flags = FLAG_Z;
            end else if (o_y.rf_wdata[15]) begin
                o_y.flags = FLAG_N;
            end else begin
                o_y.flags = FLAG_P;
            end
        end
    end
endmodule

>>> design/lc3_instruction_executor.sv
// A load word goes straight to the result register, a start word through
// S_START1 and S_START2, and a step word through fetch, operand read, indirect
// read and execute; the result register then feeds the output register. A new
// word is taken only in S_IDLE. Reset: a clearing pass zeroes memory and
// registers; no input word is taken until it ends. The core then reads halted.
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// LC-3 style core with main memory and register file in synchronous RAMs.
// ----------------------------------------------------------------------------
module lc3_instruction_executor (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lc3ex_in_if.sink    i_in,
    lc3ex_out_if.source o_out
);
    import lc3ex_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_START1, S_START2, S_IR, S_OPA, S_EX
    } t_state;

    t_state    r_state, n_state;
    t_maddr    r_cnt, n_cnt;
    t_word     r_pc, n_pc;
    t_flags    r_flags, n_flags;
    logic      r_mcr15, n_mcr15;
    t_word     r_ir, n_ir;
    t_word     r_ra, n_ra;
    t_word     r_ma, n_ma;
    logic      r_res_v, n_res_v;
    t_result   r_res, n_res;
    logic      r_out_v, n_out_v;
    t_result   r_out, n_out;

    logic      m_we, m_re, rf_we, rf_re;
    t_maddr    m_waddr, m_raddr;
    t_word     m_wdata, m_q, rf_wdata, rf_q;
    t_raddr    rf_waddr, rf_raddr;
    t_exec_in  ex_in;
    t_exec_out ex_out;
    logic      in_fire, out_move, res_load, cv;
    logic [7:0] ch;
    t_op       q_op, ir_op;
    t_word     q_ea9, ra_ea6;

    lc3ex_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_re(m_re), .i_raddr(m_raddr), .o_rdata(m_q)
    );

    lc3ex_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_rf (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_re(rf_re), .i_raddr(rf_raddr), .o_rdata(rf_q)
    );

    assign ex_in = '{ir: r_ir, pc1: r_pc + 16'd1, ra: r_ra, rb: rf_q, ma: r_ma,
                     mq: m_q, flags: r_flags};

    lc3ex_exec u_exec (.i_x(ex_in), .o_y(ex_out));

    assign out_move   = r_res_v && (!r_out_v || o_out.ready);
    assign i_in.ready = (r_state == S_IDLE) && (!r_res_v || out_move);
    assign in_fire    = i_in.valid && i_in.ready;

    assign q_op   = t_op'(m_q[15:12]);
    assign ir_op  = t_op'(r_ir[15:12]);
    assign q_ea9  = r_pc + 16'd1 + {{7{m_q[8]}}, m_q[8:0]};
    assign ra_ea6 = rf_q + {{10{r_ir[5]}}, r_ir[5:0]};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pc     = r_pc;
        n_flags  = r_flags;
        n_mcr15  = r_mcr15;
        n_ir     = r_ir;
        n_ra     = r_ra;
        n_ma     = r_ma;
        m_we     = 1'b0;
        m_waddr  = r_cnt;
        m_wdata  = 16'h0000;
        m_re     = 1'b0;
        m_raddr  = r_pc[ADDR_BITS-1:0];
        rf_we    = 1'b0;
        rf_waddr = r_cnt[RF_BITS-1:0];
        rf_wdata = 16'h0000;
        rf_re    = 1'b0;
        rf_raddr = r_ir[8:6];
        res_load = 1'b0;
        cv       = 1'b0;
        ch       = 8'h00;
        case (r_state)
            S_CLEAR: begin
                m_we = 1'b1;
                rf_we = (r_cnt < t_maddr'(RF_DEPTH));
                n_cnt = r_cnt + t_maddr'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (t_kind'(i_in.opcode))
                        KIND_LOAD: begin
                            m_we = 1'b1;
                            m_waddr = i_in.address[ADDR_BITS-1:0];
                            m_wdata = i_in.data;
                            res_load = 1'b1;
                        end
                        KIND_START: begin
                            n_pc = i_in.address;
                            n_flags = FLAG_Z;
                            m_we = 1'b1;
                            m_waddr = MCR_ADDR[ADDR_BITS-1:0];
                            m_wdata = CTRL_INIT;
                            n_state = S_START1;
                        end
                        KIND_STEP: begin
                            if (r_mcr15) begin
                                m_re = 1'b1;
                                n_state = S_IR;
                            end else begin
                                res_load = 1'b1;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_START1: begin
                m_we = 1'b1;
                m_waddr = DSR_ADDR[ADDR_BITS-1:0];
                m_wdata = CTRL_INIT;
                n_state = S_START2;
            end
            S_START2: begin
                m_we = 1'b1;
                m_waddr = DDR_ADDR[ADDR_BITS-1:0];
                m_wdata = 16'h0000;
                res_load = 1'b1;
                n_state = S_IDLE;
            end
            S_IR: begin
                n_ir = m_q;
                rf_re = 1'b1;
                case (q_op)
                    OP_ST, OP_STI:           rf_raddr = m_q[11:9];
                    OP_JSR, OP_RET, OP_TRAP: rf_raddr = LINK_REG;
                    default:                 rf_raddr = m_q[8:6];
                endcase
                case (q_op)
                    OP_LD, OP_LDI, OP_STI: begin
                        m_re = 1'b1;
                        m_raddr = q_ea9[ADDR_BITS-1:0];
                    end
                    OP_TRAP: begin
                        m_re = 1'b1;
                        m_raddr = t_maddr'(m_q[7:0]);
                    end
                    default: begin
                    end
                endcase
                n_state = S_OPA;
            end
            S_OPA: begin
                n_ra = rf_q;
                n_ma = m_q;
                rf_re = 1'b1;
                rf_raddr = (ir_op == OP_ADD || ir_op == OP_AND) ? r_ir[2:0] : r_ir[11:9];
                if (ir_op == OP_LDI) begin
                    m_re = 1'b1;
                    m_raddr = m_q[ADDR_BITS-1:0];
                end else if (ir_op == OP_LDR) begin
                    m_re = 1'b1;
                    m_raddr = ra_ea6[ADDR_BITS-1:0];
                end
                n_state = S_EX;
            end
            S_EX: begin
                n_pc = ex_out.pc;
                n_flags = ex_out.flags;
                rf_we = ex_out.rf_we;
                rf_waddr = ex_out.rf_waddr;
                rf_wdata = ex_out.rf_wdata;
                m_we = ex_out.mem_we;
                m_waddr = ex_out.mem_waddr[ADDR_BITS-1:0];
                m_wdata = ex_out.mem_wdata;
                if (ex_out.mem_we && ex_out.mem_waddr == DDR_ADDR) begin
                    cv = 1'b1;
                    ch = ex_out.mem_wdata[7:0];
                end
                res_load = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (m_we && m_waddr == MCR_ADDR[ADDR_BITS-1:0]) begin
            n_mcr15 = m_wdata[15];
        end

        n_res   = r_res;
        n_res_v = r_res_v;
        if (out_move) begin
            n_res_v = 1'b0;
        end
        if (res_load) begin
            n_res_v = 1'b1;
            n_res = '{pc: n_pc, cc: n_flags, halted: !n_mcr15, char_valid: cv,
                      char_code: ch};
        end

        n_out   = r_out;
        n_out_v = r_out_v;
        if (out_move) begin
            n_out = r_res;
            n_out_v = 1'b1;
        end else if (o_out.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pc    <= 16'h0000;
            r_flags <= 3'b000;
            r_mcr15 <= 1'b0;
            r_res_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
            r_flags <= n_flags;
            r_mcr15 <= n_mcr15;
            r_res_v <= n_res_v;
            r_out_v <= n_out_v;
        end
        r_ir  <= n_ir;
        r_ra  <= n_ra;
        r_ma  <= n_ma;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out.valid           = r_out_v;
    assign o_out.program_counter = r_out.pc;
    assign o_out.cond_codes      = r_out.cc;
    assign o_out.halted          = r_out.halted;
    assign o_out.char_valid      = r_out.char_valid;
    assign o_out.char_code       = r_out.char_code;

`ifndef ASSERT_OFF
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input taken during clearing pass");

    a_ex_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) |=> r_res_v)
        else $error("executed step left no result");

    a_fetch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IR) |-> ($past(r_state) == S_IDLE))
        else $error("decode without fetch");
`endif
endmodule
